### hdl/swc_pkg.sv
// Shared types and constants of the sliding-window Cpk block.
`timescale 1ns / 1ps
package swc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int LIMIT_W  = 16;
  localparam int CPK_W    = 16;
  localparam int HELD_W   = 11;
  localparam int ROOT_W   = 16;

  // Configuration register indexes
  localparam logic REG_LOWER = 1'b0;
  localparam logic REG_UPPER = 1'b1;

  localparam logic [LIMIT_W-1:0] LOWER_RESET = 16'd21910;
  localparam logic [LIMIT_W-1:0] UPPER_RESET = 16'd22090;

  // Q8.8 saturation bounds of the magnitude
  localparam logic [ROOT_W-1:0] POS_MAX = 16'd32767;
  localparam logic [ROOT_W-1:0] NEG_MAX = 16'd32768;

  // One classified sample as it travels from front to back
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                above;
    logic                below;
  } swc_item_t;

endpackage

### hdl/swc_front.sv
// Front end: accepts samples and flags them against the specification limits.
`timescale 1ns / 1ps
module swc_front
  import swc_pkg::*;
(
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [LIMIT_W-1:0]  lower_limit_i,
  input  logic [LIMIT_W-1:0]  upper_limit_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output swc_item_t           q_item_o
);

  logic above;

  // Stall while the queue has no room
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Classify the sample; upper wins when limits are inverted
  assign above = sample_i > upper_limit_i;
  always_comb begin
    q_item_o.sample = sample_i;
    q_item_o.above  = above;
    q_item_o.below  = !above && (sample_i < lower_limit_i);
  end

endmodule

### hdl/swc_queue.sv
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps
module swc_queue
  import swc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  swc_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output swc_item_t item_o
);

  swc_item_t   slot_q [2];
  logic        wr_q, wr_d;
  logic        rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign item_o  = slot_q[rd_q];

  // Advance pointers and count
  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= item_i;
    end
  end

endmodule

### hdl/swc_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle, early exit.
`timescale 1ns / 1ps
module swc_mul #(
  parameter int AW = 101,
  parameter int BW = 28
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  output logic          done_o,
  output logic [AW-1:0] prod_o
);

  logic          busy_q;
  logic          done_q;
  logic [AW-1:0] acc_q;
  logic [AW-1:0] a_q;
  logic [BW-1:0] b_q;

  assign done_o = done_q;
  assign prod_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (b_q == '0)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Add the shifted multiplicand for each set bit
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
    end else if (busy_q && (b_q != '0)) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[AW-2:0], 1'b0};
      b_q <= {1'b0, b_q[BW-1:1]};
    end
  end

endmodule

### hdl/swc_back.sv
// Back end: window store, running sums and the Cpk sequencer.
`timescale 1ns / 1ps
module swc_back
  import swc_pkg::*;
#(
  parameter int WINDOW_DEPTH = 1024,
  parameter int MIN_SAMPLES  = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  swc_item_t           q_item_i,
  output logic                q_pop_o,
  input  logic [LIMIT_W-1:0]  lower_limit_i,
  input  logic [LIMIT_W-1:0]  upper_limit_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CPK_W-1:0]    cpk_value_o,
  output logic                cpk_valid_o,
  output logic                above_upper_o,
  output logic                below_lower_o,
  output logic [HELD_W-1:0]   samples_held_o
);

  localparam int NW = $clog2(WINDOW_DEPTH + 1);
  localparam int PW = $clog2(WINDOW_DEPTH);
  localparam int SW = SAMPLE_W + NW;
  localparam int QW = 2 * SAMPLE_W + NW;
  localparam int DW = NW + QW;
  localparam int MW = SW + 1;
  localparam int AW = 3 * NW + 68;
  localparam int BW = MW;
  localparam int KSHIFT = 2 * (ROOT_W - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_UPD, ST_NQ_GO, ST_NQ_WAIT, ST_SS_GO, ST_SS_WAIT, ST_CHECK,
    ST_MM_GO, ST_MM_WAIT, ST_MN_GO, ST_MN_WAIT, ST_K_GO, ST_K_WAIT,
    ST_ROOT, ST_OUT
  } state_e;

  state_e              state_q;
  logic [SAMPLE_W-1:0] mem [WINDOW_DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;
  logic [PW-1:0]       wp_q;
  logic [NW-1:0]       fill_q;
  logic [SW-1:0]       sum_q;
  logic [QW-1:0]       sq_q;
  logic [SAMPLE_W-1:0] x_q;
  logic                above_q, below_q;
  logic [DW-1:0]       nq_q, d_q;
  logic                neg_q, ok_q;
  logic [MW-1:0]       mag_q;
  logic [AW-1:0]       rhs_q, t_q, pk_q, kk_q;
  logic [ROOT_W-1:0]   r_q;
  logic [3:0]          bit_q;
  logic                out_valid_q;
  logic [CPK_W-1:0]    cpk_q;
  logic                cpkv_q, au_q, bl_q;
  logic [HELD_W-1:0]   held_q;

  logic                full;
  logic [SAMPLE_W-1:0] old;
  logic [2*SAMPLE_W-1:0] old_sq, x_sq;
  logic                mul_start, mul_done;
  logic [AW-1:0]       mul_a, mul_prod;
  logic [BW-1:0]       mul_b;
  logic [SW-1:0]       nu, nl;
  logic signed [MW:0]  cu, cl, m;
  logic [AW-1:0]       cand;
  logic                take;
  logic [ROOT_W-1:0]   r_sat;
  logic                out_free;

  assign full    = 32'(fill_q) >= 32'(WINDOW_DEPTH);
  assign old     = full ? rdata_q : '0;
  assign old_sq  = old * old;
  assign x_sq    = x_q * x_q;
  assign q_pop_o = (state_q == ST_IDLE) && q_valid_i;

  // Select multiplier operands by step
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_q)
      ST_NQ_GO: begin
        mul_start = 1'b1;
        mul_a     = AW'(sq_q);
        mul_b     = BW'(fill_q);
      end
      ST_SS_GO: begin
        mul_start = 1'b1;
        mul_a     = AW'(sum_q);
        mul_b     = BW'(sum_q);
      end
      ST_MM_GO: begin
        mul_start = 1'b1;
        mul_a     = AW'(mag_q);
        mul_b     = BW'(mag_q);
      end
      ST_MN_GO: begin
        mul_start = 1'b1;
        mul_a     = rhs_q;
        mul_b     = BW'(fill_q - NW'(1));
      end
      ST_K_GO: begin
        mul_start = 1'b1;
        mul_a     = AW'(d_q);
        mul_b     = BW'({fill_q, 3'b000}) + BW'(fill_q);
      end
      default: begin
      end
    endcase
  end

  swc_mul #(
    .AW(AW),
    .BW(BW)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  // Distances of the sum to n times each limit
  always_comb begin
    nu = SW'(fill_q) * SW'(upper_limit_i);
    nl = SW'(fill_q) * SW'(lower_limit_i);
    cu = $signed({2'b00, nu}) - $signed({2'b00, sum_q});
    cl = $signed({2'b00, sum_q}) - $signed({2'b00, nl});
    m  = (cu < cl) ? cu : cl;
  end

  // One step of the root search, most significant bit first
  assign cand = t_q + pk_q + kk_q;
  assign take = cand <= rhs_q;

  always_comb begin
    if (neg_q) begin
      r_sat = (r_q > NEG_MAX) ? NEG_MAX : r_q;
    end else begin
      r_sat = (r_q > POS_MAX) ? POS_MAX : r_q;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // Window store with registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[wp_q];
    if (state_q == ST_UPD) begin
      mem[wp_q] <= x_q;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      sq_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            x_q     <= q_item_i.sample;
            above_q <= q_item_i.above;
            below_q <= q_item_i.below;
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          sum_q <= sum_q - SW'(old) + SW'(x_q);
          sq_q  <= sq_q - QW'(old_sq) + QW'(x_sq);
          if (!full) begin
            fill_q <= fill_q + NW'(1);
          end
          wp_q    <= (32'(wp_q) + 1 >= WINDOW_DEPTH) ? '0 : wp_q + PW'(1);
          state_q <= ST_NQ_GO;
        end
        ST_NQ_GO: state_q <= ST_NQ_WAIT;
        ST_NQ_WAIT: begin
          if (mul_done) begin
            nq_q    <= DW'(mul_prod);
            state_q <= ST_SS_GO;
          end
        end
        ST_SS_GO: state_q <= ST_SS_WAIT;
        ST_SS_WAIT: begin
          if (mul_done) begin
            d_q     <= (nq_q > DW'(mul_prod)) ? nq_q - DW'(mul_prod) : '0;
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          neg_q <= m < 0;
          mag_q <= (m < 0) ? MW'(-m) : MW'(m);
          r_q   <= '0;
          if ((32'(fill_q) >= 32'(MIN_SAMPLES)) && (d_q != '0)) begin
            ok_q    <= 1'b1;
            state_q <= ST_MM_GO;
          end else begin
            ok_q    <= 1'b0;
            state_q <= ST_OUT;
          end
        end
        ST_MM_GO: state_q <= ST_MM_WAIT;
        ST_MM_WAIT: begin
          if (mul_done) begin
            rhs_q   <= mul_prod;
            state_q <= ST_MN_GO;
          end
        end
        ST_MN_GO: state_q <= ST_MN_WAIT;
        ST_MN_WAIT: begin
          if (mul_done) begin
            rhs_q   <= mul_prod << 16;
            state_q <= ST_K_GO;
          end
        end
        ST_K_GO: state_q <= ST_K_WAIT;
        ST_K_WAIT: begin
          if (mul_done) begin
            kk_q    <= mul_prod << KSHIFT;
            pk_q    <= '0;
            t_q     <= '0;
            bit_q   <= 4'(ROOT_W - 1);
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          // keep t = r^2 K, pk = r K scaled to the bit, kk = K scaled to the bit
          if (take) begin
            t_q        <= cand;
            r_q[bit_q] <= 1'b1;
            pk_q       <= (pk_q >> 1) + kk_q;
          end else begin
            pk_q <= pk_q >> 1;
          end
          kk_q <= kk_q >> 2;
          if (bit_q == 4'd0) begin
            state_q <= ST_OUT;
          end else begin
            bit_q <= bit_q - 4'd1;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            cpkv_q      <= ok_q;
            if (!ok_q) begin
              cpk_q <= '0;
            end else if (neg_q) begin
              cpk_q <= CPK_W'(-r_sat);
            end else begin
              cpk_q <= CPK_W'(r_sat);
            end
            au_q    <= above_q;
            bl_q    <= below_q;
            held_q  <= HELD_W'(fill_q);
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cpk_value_o    = cpk_q;
  assign cpk_valid_o    = cpkv_q;
  assign above_upper_o  = au_q;
  assign below_lower_o  = bl_q;
  assign samples_held_o = held_q;

endmodule

### hdl/sliding_window_cpk_core.sv
// Top level of the sliding-window Cpk block: limits, front end, queue, back end.
//
// Usage: one 16-bit sample, in hundredths of a unit, enters per transaction on
// the input channel (in_valid_i, in_stall_o, sample_i). Each sample gives one
// result transaction on the output channel: Cpk in signed Q8.8, its valid
// flag, the two limit flags and the number of samples now in the window.
// Limits are written through cfg_we_i, cfg_addr_i and cfg_wdata_i while the
// block is idle; index 0 is the lower limit, index 1 the upper limit.
// Each result is worked out by the sequencer with five serial products
// (narrow operands n, the sum, the magnitude, n-1 and 9n) and a root
// search, most significant bit first. A sample that gives no valid Cpk
// skips the last three products and the root search. The back end
// handles one sample at a time and takes no new sample before its result
// has been presented. A two-entry queue lets the front end take up to two
// more samples meanwhile. Reset empties the window, zeroes the sums and
// loads the default limits; no clearing pass is needed. A stalled result
// is held in the output register and the back end waits in its last step
// before presenting the next one.
`timescale 1ns / 1ps
module sliding_window_cpk_core
  import swc_pkg::*;
#(
  parameter int WINDOW_DEPTH = 1024,
  parameter int MIN_SAMPLES  = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_addr_i,
  input  logic [LIMIT_W-1:0]  cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CPK_W-1:0]    cpk_value_o,
  output logic                cpk_valid_o,
  output logic                above_upper_o,
  output logic                below_lower_o,
  output logic [HELD_W-1:0]   samples_held_o
);

  logic [LIMIT_W-1:0] lower_q;
  logic [LIMIT_W-1:0] upper_q;
  logic               q_push, q_full, q_pop, q_valid;
  swc_item_t          push_item, pop_item;

  // Specification limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= LOWER_RESET;
      upper_q <= UPPER_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_LOWER: lower_q <= cfg_wdata_i;
        REG_UPPER: upper_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  swc_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .lower_limit_i(lower_q),
    .upper_limit_i(upper_q),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_item_o     (push_item)
  );

  swc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (push_item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .item_o (pop_item)
  );

  swc_back #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .MIN_SAMPLES (MIN_SAMPLES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (pop_item),
    .q_pop_o       (q_pop),
    .lower_limit_i (lower_q),
    .upper_limit_i (upper_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cpk_value_o   (cpk_value_o),
    .cpk_valid_o   (cpk_valid_o),
    .above_upper_o (above_upper_o),
    .below_lower_o (below_lower_o),
    .samples_held_o(samples_held_o)
  );

endmodule

### tb/sv/sliding_window_cpk_core_tb.sv
// Self-checking testbench of the sliding-window Cpk block with its own Cpk predictor.
`timescale 1ns / 1ps
module sliding_window_cpk_core_tb;
  import swc_pkg::*;

  localparam int DEPTH      = 1024;
  localparam int MIN_N      = 10;
  localparam int DRAIN_WAIT = 300;
  localparam int STALL_MAX  = 20000;

  typedef struct {
    logic [CPK_W-1:0]  cpk;
    logic              vld;
    logic              above;
    logic              below;
    logic [HELD_W-1:0] held;
  } cpk_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we = 1'b0;
  logic                cfg_addr = REG_LOWER;
  logic [LIMIT_W-1:0]  cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] sample = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [CPK_W-1:0]    cpk_value;
  logic                cpk_valid;
  logic                above_upper;
  logic                below_lower;
  logic [HELD_W-1:0]   samples_held;

  sliding_window_cpk_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_addr_i(cfg_addr), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .sample_i(sample),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .cpk_value_o(cpk_value), .cpk_valid_o(cpk_valid),
    .above_upper_o(above_upper), .below_lower_o(below_lower),
    .samples_held_o(samples_held)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Predictor state: window, sums and the limits as last written
  logic [SAMPLE_W-1:0] window_ring [DEPTH];
  int unsigned         ring_wr;
  int unsigned         ring_fill;
  logic [63:0]         win_sum;
  logic [63:0]         win_sq_sum;
  logic [LIMIT_W-1:0]  lim_lower = LOWER_RESET;
  logic [LIMIT_W-1:0]  lim_upper = UPPER_RESET;

  logic [SAMPLE_W-1:0] pending_samples[$];
  cpk_result_t         expected_results[$];
  bit                  no_idle;
  int                  mismatches;
  int                  n_sent;
  int                  n_checked;
  int                  n_cpk_valid;
  int                  idle_cycles;

  // Append one sample to the driver queue
  task automatic add_sample(input logic [SAMPLE_W-1:0] x);
    pending_samples.insert(pending_samples.size(), x);
  endtask

  // Update the window with one sample and queue the result it should give
  task automatic predict_cpk(input logic [SAMPLE_W-1:0] x);
    logic [63:0]  n, s, q, nq, ss, d, mag;
    longint       cu, cl, m;
    logic [127:0] rhs, lhs;
    int unsigned  lo, hi, mid;
    cpk_result_t  r;
    if (ring_fill >= DEPTH) begin
      win_sum    -= window_ring[ring_wr];
      win_sq_sum -= 64'(window_ring[ring_wr]) * 64'(window_ring[ring_wr]);
    end else begin
      ring_fill++;
    end
    window_ring[ring_wr] = x;
    win_sum    += x;
    win_sq_sum += 64'(x) * 64'(x);
    ring_wr = (ring_wr + 1 >= DEPTH) ? 0 : ring_wr + 1;
    n  = ring_fill;
    s  = win_sum;
    q  = win_sq_sum;
    nq = n * q;
    ss = s * s;
    d  = (nq > ss) ? nq - ss : 64'd0;
    r.cpk = '0;
    r.vld = 1'b0;
    if (n >= MIN_N && d != 0) begin
      cu  = longint'(n * lim_upper) - longint'(s);
      cl  = longint'(s) - longint'(n * lim_lower);
      m   = (cu < cl) ? cu : cl;
      mag = (m < 0) ? 64'(-m) : 64'(m);
      rhs = (128'(mag * (n - 1)) * 128'(mag)) << 16;
      // largest magnitude whose square times 9*n*d stays within rhs
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        lhs = 128'(64'(mid) * 64'(mid) * 64'd9 * n) * 128'(d);
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      if (m < 0) r.cpk = CPK_W'(-int'(lo));
      else r.cpk = (lo > 32767) ? CPK_W'(POS_MAX) : CPK_W'(lo);
      r.vld = 1'b1;
    end
    r.above = x > lim_upper;
    r.below = !r.above && (x < lim_lower);
    r.held  = HELD_W'(ring_fill);
    expected_results.insert(expected_results.size(), r);
  endtask

  // Driver: present queued samples with random gaps, predict on each transaction
  int unsigned in_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_cpk(sample);
        n_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          sample   <= pending_samples.pop_front();
          in_valid <= 1'b1;
          in_gap   <= no_idle ? 0 : $urandom_range(0, 4);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stalls on results, compare each transaction field by field
  int unsigned out_wait;
  always @(posedge clk_i or negedge rst_ni) begin
    cpk_result_t e;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      out_wait  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_checked++;
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: cpk_value %0d", $signed(cpk_value));
          mismatches++;
        end else begin
          e = expected_results.pop_front();
          if (e.vld) n_cpk_valid++;
          if (cpk_value !== e.cpk) begin
            $error("cpk_value: expected %0d, actual %0d", $signed(e.cpk), $signed(cpk_value));
            mismatches++;
          end
          if (cpk_valid !== e.vld) begin
            $error("cpk_valid: expected %0b, actual %0b", e.vld, cpk_valid);
            mismatches++;
          end
          if (above_upper !== e.above) begin
            $error("above_upper: expected %0b, actual %0b", e.above, above_upper);
            mismatches++;
          end
          if (below_lower !== e.below) begin
            $error("below_lower: expected %0b, actual %0b", e.below, below_lower);
            mismatches++;
          end
          if (samples_held !== e.held) begin
            $error("samples_held: expected %0d, actual %0d", e.held, samples_held);
            mismatches++;
          end
        end
        out_wait <= no_idle ? 0 : $urandom_range(0, 4);
      end
      // hold stall while the drawn wait counts down, then release
      if (out_wait > 0 && !(out_valid && !out_stall)) begin
        out_wait  <= out_wait - 1;
        out_stall <= 1'b1;
      end else if (!(out_valid && !out_stall)) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= !no_idle && ($urandom_range(0, 1) == 1);
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_MAX) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic wait_drained();
    wait (pending_samples.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic idx, input logic [LIMIT_W-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_LOWER) lim_lower = val;
    else lim_upper = val;
  endtask

  // Queue samples spread around a center, with some full-range noise
  task automatic queue_spread(input int center, input int spread, input int count);
    int v;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 15) begin
        v = $urandom_range(0, 65535);
      end else begin
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
      end
      add_sample(SAMPLE_W'(v));
    end
  endtask

  initial begin
    int lo_l [6] = '{0, 65535, 21910, 1000, 0, 30000};
    int up_l [6] = '{65535, 0, 22090, 1100, 0, 30000};
    int spreads [4] = '{1, 10, 100, 1000};
    int c;
    idle_cycles = 0;
    mismatches  = 0;
    ring_wr     = 0;
    ring_fill   = 0;
    win_sum     = '0;
    win_sq_sum  = '0;
    no_idle     = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: constant samples give zero variance, then limit edges and extremes
    for (int i = 0; i < 11; i++) add_sample(16'd22000);
    add_sample(16'd21910);
    add_sample(16'd22090);
    add_sample(16'd21909);
    add_sample(16'd22091);
    add_sample(16'd0);
    add_sample(16'd65535);
    add_sample(16'hAAAA);
    add_sample(16'h5555);
    add_sample(16'd22000);
    wait_drained();

    // Random phases, each under its own pair of limits
    for (int p = 0; p < 6; p++) begin
      if (p == 5) begin
        lo_l[p] = $urandom_range(0, 65535);
        up_l[p] = $urandom_range(0, 65535);
      end
      write_limit(REG_LOWER, LIMIT_W'(lo_l[p]));
      write_limit(REG_UPPER, LIMIT_W'(up_l[p]));
      no_idle = (p == 2);
      for (int k = 0; k < 6; k++) begin
        if ($urandom_range(0, 1) == 1) c = (lo_l[p] + up_l[p]) / 2;
        else c = $urandom_range(0, 65535);
        queue_spread(c, spreads[$urandom_range(0, 3)], 50);
        // hold off the sender once until every result is back
        if (p == 3 && k == 2) begin
          wait (pending_samples.size() == 0 && !in_valid && expected_results.size() == 0);
        end
      end
      wait_drained();
    end

    $display("Sent %0d samples and checked %0d results, %0d with a valid Cpk,",
             n_sent, n_checked, n_cpk_valid);
    $display("over six limit settings including full range, inverted and reset limits.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sliding_window_cpk_core.f
hdl/swc_pkg.sv
hdl/swc_front.sv
hdl/swc_queue.sv
hdl/swc_mul.sv
hdl/swc_back.sv
hdl/sliding_window_cpk_core.sv
tb/sv/sliding_window_cpk_core_tb.sv
